### design/logical_line_assembler_macros.svh
// assertion helpers used by the checker file
`ifndef LOGICAL_LINE_ASSEMBLER_MACROS_SVH
`define LOGICAL_LINE_ASSEMBLER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define LLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lla_pkg.sv
package lla_pkg;

	localparam int CNT_W = 13;
	localparam int NRES  = 4;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BSL  = 8'h5c;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0a;
	localparam logic [7:0] CH_NUL  = 8'h00;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_SKIP   = 3'b100
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_LINE     = 2'd1,
		KIND_OVERFLOW = 2'd2,
		KIND_END      = 2'd3
	} kind_t;

	typedef struct packed {
		mode_t            mode;
		logic             sp;
		logic [CNT_W-1:0] cnt;
	} state_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       ch;
		logic [CNT_W-1:0] len;
	} res_t;

endpackage

### design/lla_step.sv
module lla_step (
	input  logic [7:0]                 in_byte,
	input  logic                       eoi,
	input  lla_pkg::state_t            st,
	input  logic [lla_pkg::CNT_W-1:0]  lim,
	output lla_pkg::state_t            st_nxt,
	output lla_pkg::res_t              res [lla_pkg::NRES],
	output logic [2:0]                 n_res
);

	always_comb begin
		logic [lla_pkg::CNT_W-1:0] c1;
		logic [lla_pkg::CNT_W-1:0] c2;
		logic [2:0]                n;
		st_nxt = st;
		n = 3'd0;
		for (int i = 0; i < lla_pkg::NRES; i++) begin
			res[i] = '0;
		end
		c1 = st.cnt + lla_pkg::CNT_W'(1);
		c2 = st.cnt + lla_pkg::CNT_W'(2);

		if (eoi) begin
			if (st.cnt != '0) begin
				res[n[1:0]] = '{lla_pkg::KIND_LINE, 8'h00,
					st.cnt - lla_pkg::CNT_W'(st.sp)};
				n = n + 3'd1;
			end
			res[n[1:0]] = '{lla_pkg::KIND_END, 8'h00, '0};
			n = n + 3'd1;
			st_nxt = '{lla_pkg::MODE_NORMAL, 1'b0, '0};
		end else begin
			case (st.mode)
				lla_pkg::MODE_SKIP: begin
					if (in_byte == lla_pkg::CH_NL) st_nxt.mode = lla_pkg::MODE_NORMAL;
				end
				lla_pkg::MODE_ESCAPE: begin
					st_nxt.mode = lla_pkg::MODE_NORMAL;
					if (in_byte == lla_pkg::CH_NL) begin
						// continuation onto the next physical line
					end else if (in_byte inside {lla_pkg::CH_SP, lla_pkg::CH_TAB,
							lla_pkg::CH_NUL}) begin
						st_nxt.mode = lla_pkg::MODE_SKIP;
					end else begin
						if (st.sp) begin
							res[n[1:0]] = '{lla_pkg::KIND_CHAR, lla_pkg::CH_SP, '0};
							n = n + 3'd1;
						end
						st_nxt.sp = 1'b0;
						res[n[1:0]] = '{lla_pkg::KIND_CHAR, lla_pkg::CH_BSL, '0};
						n = n + 3'd1;
						if (c1 >= lim) begin
							// backslash hit the limit, its partner is dropped
							res[n[1:0]] = '{lla_pkg::KIND_OVERFLOW, 8'h00, '0};
							n = n + 3'd1;
							st_nxt = '{lla_pkg::MODE_SKIP, 1'b0, '0};
						end else begin
							res[n[1:0]] = '{lla_pkg::KIND_CHAR, in_byte, '0};
							n = n + 3'd1;
							st_nxt.cnt = c2;
							if (c2 >= lim) begin
								res[n[1:0]] = '{lla_pkg::KIND_OVERFLOW, 8'h00, '0};
								n = n + 3'd1;
								st_nxt = '{lla_pkg::MODE_SKIP, 1'b0, '0};
							end
						end
					end
				end
				default: begin
					if (in_byte == lla_pkg::CH_HASH || in_byte == lla_pkg::CH_NL) begin
						if (st.cnt != '0) begin
							res[n[1:0]] = '{lla_pkg::KIND_LINE, 8'h00,
								st.cnt - lla_pkg::CNT_W'(st.sp)};
							n = n + 3'd1;
						end
						st_nxt.sp  = 1'b0;
						st_nxt.cnt = '0;
						if (in_byte == lla_pkg::CH_HASH) st_nxt.mode = lla_pkg::MODE_SKIP;
					end else if (in_byte inside {lla_pkg::CH_SP, lla_pkg::CH_TAB}) begin
						// fold the run, the held space already counts
						if (st.cnt != '0 && !st.sp) begin
							st_nxt.sp  = 1'b1;
							st_nxt.cnt = c1;
							if (c1 >= lim) begin
								res[n[1:0]] = '{lla_pkg::KIND_CHAR, lla_pkg::CH_SP, '0};
								n = n + 3'd1;
								res[n[1:0]] = '{lla_pkg::KIND_OVERFLOW, 8'h00, '0};
								n = n + 3'd1;
								st_nxt = '{lla_pkg::MODE_SKIP, 1'b0, '0};
							end
						end
					end else if (in_byte == lla_pkg::CH_BSL) begin
						st_nxt.mode = lla_pkg::MODE_ESCAPE;
					end else if (in_byte == lla_pkg::CH_NUL) begin
						st_nxt.mode = lla_pkg::MODE_SKIP;
					end else begin
						if (st.sp) begin
							res[n[1:0]] = '{lla_pkg::KIND_CHAR, lla_pkg::CH_SP, '0};
							n = n + 3'd1;
						end
						st_nxt.sp = 1'b0;
						res[n[1:0]] = '{lla_pkg::KIND_CHAR, in_byte, '0};
						n = n + 3'd1;
						st_nxt.cnt = c1;
						if (c1 >= lim) begin
							res[n[1:0]] = '{lla_pkg::KIND_OVERFLOW, 8'h00, '0};
							n = n + 3'd1;
							st_nxt = '{lla_pkg::MODE_SKIP, 1'b0, '0};
						end
					end
				end
			endcase
		end
		n_res = n;
	end

endmodule

### design/logical_line_assembler.sv
// a beat's first result is registered and shows in the cycle after acceptance
// throughput: one input beat per cycle while the output is not stalled and
// each beat yields at most one result; a beat with k results (up to 4) holds off
// new beats while its list drains one beat per cycle via a single output register
// reset: parser back to normal mode, empty line, no held space, result list empty,
// max_len back to 256, or to LIMIT_MAX if that is smaller
module logical_line_assembler #(
	parameter int LIMIT_MAX = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,       // max_len
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic [0:0]  s_axis_tuser,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_char, line_length, zero pad
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast    // last
);

	localparam int CW = lla_pkg::CNT_W;
	localparam logic [CW-1:0] LIM_RST = CW'((LIMIT_MAX < 256) ? LIMIT_MAX : 256);

	logic [CW-1:0]   lim_q;
	lla_pkg::state_t st_q;
	lla_pkg::state_t st_nxt;
	lla_pkg::res_t   list_q [lla_pkg::NRES];
	lla_pkg::res_t   res    [lla_pkg::NRES];
	logic [2:0]      n_q;
	logic [2:0]      n_res;
	logic            in_acc;
	logic            out_acc;
	logic [CW-1:0]   lim_wr;

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = (n_q != 3'd0);
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (n_q == 3'd0) || (n_q == 3'd1 && m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// clamp the written limit once, at write time
	always_comb begin
		if (cfg_data == 13'd0) begin
			lim_wr = CW'(1);
		end else if (32'(cfg_data) > LIMIT_MAX) begin
			lim_wr = CW'(LIMIT_MAX);
		end else begin
			lim_wr = cfg_data;
		end
	end

	lla_step u_step (
		.in_byte (s_axis_tdata),
		.eoi     (s_axis_tuser[0]),
		.st      (st_q),
		.lim     (lim_q),
		.st_nxt  (st_nxt),
		.res     (res),
		.n_res   (n_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RST;
			st_q  <= '{lla_pkg::MODE_NORMAL, 1'b0, '0};
			n_q   <= 3'd0;
		end else begin
			if (cfg_valid && cfg_ready) lim_q <= lim_wr;
			if (in_acc) st_q <= st_nxt;
			if (in_acc && n_res != 3'd0) begin
				n_q <= n_res;
			end else if (out_acc) begin
				n_q <= n_q - 3'd1;
			end
		end
	end

	// result list, head in slot 0, shifts down as beats leave
	always_ff @(posedge clk) begin
		if (in_acc && n_res != 3'd0) begin
			list_q <= res;
		end else if (out_acc) begin
			for (int i = 0; i < lla_pkg::NRES - 1; i++) begin
				list_q[i] <= list_q[i+1];
			end
		end
	end

	assign m_axis_tuser = list_q[0].kind;
	assign m_axis_tdata = {3'b000, list_q[0].len, list_q[0].ch};
	assign m_axis_tlast = (n_q == 3'd1);

endmodule

### design/lla_checker.sv
`include "logical_line_assembler_macros.svh"

module lla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	logic out_held;

	assign out_held = m_axis_tvalid && !m_axis_tready;

	`LLA_ASSERT_NXT(a_hold, clk, arst_n, out_held, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output beat changed")
	`LLA_ASSERT_IMP(a_char_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != lla_pkg::KIND_CHAR, m_axis_tdata[7:0] == 8'h00, "out_char set on a non-character beat")
	`LLA_ASSERT_IMP(a_len_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != lla_pkg::KIND_LINE, m_axis_tdata[20:8] == 13'd0, "line_length set on a beat that is not line complete")
	`LLA_ASSERT_IMP(a_term_last, clk, arst_n, m_axis_tvalid && (m_axis_tuser == lla_pkg::KIND_OVERFLOW || m_axis_tuser == lla_pkg::KIND_END), m_axis_tlast, "overflow or end beat not marked last")

endmodule

bind logical_line_assembler lla_checker u_lla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int LIMIT_MAX = 4096;
	localparam int N_DIRECTED = 26;
	localparam int N_PHASES = 10;
	localparam int BYTES_PER_PHASE = 42;

	typedef struct packed {
		lla_pkg::kind_t            kind;
		logic [7:0]                ch;
		logic [lla_pkg::CNT_W-1:0] len;
		logic                      last;
	} line_result_t;

	// one row of directed text; typed rows carry their single result
	typedef struct packed {
		logic [7:0]                b;
		logic                      eoi;
		logic                      typed;
		lla_pkg::kind_t            kind;
		logic [7:0]                ch;
		logic [lla_pkg::CNT_W-1:0] len;
	} text_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // in_byte
	logic [0:0]  s_axis_tuser = '0;   // end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // out_char, line_length, zero pad
	logic [1:0]  m_axis_tuser;        // kind
	logic        m_axis_tlast;

	logical_line_assembler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// line assembler state as the testbench sees it
	lla_pkg::mode_t            parse_st;
	logic                      held_space;
	logic [lla_pkg::CNT_W-1:0] line_count;
	logic [12:0]               max_len_reg;
	line_result_t              step_results [$];
	line_result_t              awaited_results [$];

	int  mismatches = 0;
	int  results_checked = 0;
	int  lines_seen = 0;
	int  overflows_seen = 0;
	int  bytes_accepted = 0;
	int  steady_items = 0;
	bit  squeeze_armed = 1'b0;

	function automatic logic [lla_pkg::CNT_W-1:0] line_limit();
		if (max_len_reg == 0)
			return lla_pkg::CNT_W'(1);
		if (max_len_reg > LIMIT_MAX)
			return lla_pkg::CNT_W'(LIMIT_MAX);
		return max_len_reg;
	endfunction

	function automatic void note(lla_pkg::kind_t k, logic [7:0] c,
			logic [lla_pkg::CNT_W-1:0] n);
		step_results.push_back('{kind: k, ch: c, len: n, last: 1'b0});
	endfunction

	// overflow drops the line and skips to the next newline
	function automatic logic room_left();
		if (line_count >= line_limit()) begin
			note(lla_pkg::KIND_OVERFLOW, 8'h00, '0);
			line_count = '0;
			held_space = 1'b0;
			parse_st = lla_pkg::MODE_SKIP;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void flush_space();
		if (held_space) begin
			note(lla_pkg::KIND_CHAR, lla_pkg::CH_SP, '0);
			held_space = 1'b0;
		end
	endfunction

	function automatic logic keep_char(logic [7:0] c);
		note(lla_pkg::KIND_CHAR, c, '0);
		line_count++;
		return room_left();
	endfunction

	function automatic void close_line();
		if (line_count != 0)
			note(lla_pkg::KIND_LINE, 8'h00, line_count - held_space);
		line_count = '0;
		held_space = 1'b0;
	endfunction

	function automatic void assemble_byte(logic [7:0] c, logic eoi);
		line_result_t tail;
		step_results.delete();
		if (eoi) begin
			close_line();
			note(lla_pkg::KIND_END, 8'h00, '0);
			parse_st = lla_pkg::MODE_NORMAL;
		end else begin
			case (parse_st)
				lla_pkg::MODE_SKIP: begin
					if (c == lla_pkg::CH_NL)
						parse_st = lla_pkg::MODE_NORMAL;
				end
				lla_pkg::MODE_ESCAPE: begin
					parse_st = lla_pkg::MODE_NORMAL;
					if (c == lla_pkg::CH_SP || c == lla_pkg::CH_TAB
							|| c == lla_pkg::CH_NUL) begin
						parse_st = lla_pkg::MODE_SKIP;
					end else if (c != lla_pkg::CH_NL) begin
						flush_space();
						if (keep_char(lla_pkg::CH_BSL))
							void'(keep_char(c));
					end
				end
				default: begin
					if (c == lla_pkg::CH_HASH) begin
						close_line();
						parse_st = lla_pkg::MODE_SKIP;
					end else if (c == lla_pkg::CH_NL) begin
						close_line();
					end else if (c == lla_pkg::CH_SP || c == lla_pkg::CH_TAB) begin
						// folded space counts as soon as it is held
						if (line_count != 0 && !held_space) begin
							held_space = 1'b1;
							line_count++;
							if (line_count >= line_limit()) begin
								flush_space();
								void'(room_left());
							end
						end
					end else if (c == lla_pkg::CH_BSL) begin
						parse_st = lla_pkg::MODE_ESCAPE;
					end else if (c == lla_pkg::CH_NUL) begin
						parse_st = lla_pkg::MODE_SKIP;
					end else begin
						flush_space();
						void'(keep_char(c));
					end
				end
			endcase
		end
		if (step_results.size() > 0) begin
			tail = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
	endfunction

	function automatic void flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", what);
	endfunction

	// mostly words, blanks and newlines, with comments, escapes and noise mixed in
	function automatic void pick_text(output logic [7:0] b, output logic eoi);
		int r;
		r = $urandom_range(0, 99);
		eoi = 1'b0;
		if (r < 55)
			b = 8'($urandom_range(8'h21, 8'h7e));
		else if (r < 70)
			b = lla_pkg::CH_SP;
		else if (r < 75)
			b = lla_pkg::CH_TAB;
		else if (r < 85)
			b = lla_pkg::CH_NL;
		else if (r < 89)
			b = lla_pkg::CH_HASH;
		else if (r < 93)
			b = lla_pkg::CH_BSL;
		else if (r < 95)
			b = lla_pkg::CH_NUL;
		else if (r < 98)
			b = 8'($urandom_range(0, 255));
		else begin
			b = 8'($urandom_range(0, 255));
			eoi = 1'b1;
		end
	endfunction

	task automatic send_row(input text_row_t row);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady_items > 0) begin
			steady_items--;
			gap = 0;
		end else if (r < 3) begin
			steady_items = 40;
			gap = 0;
		end else if (r < 70) begin
			gap = 0;
		end else if (r < 95) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= row.b;
		s_axis_tuser <= row.eoi;
		do @(posedge clk); while (!s_axis_tready);
		bytes_accepted++;
		assemble_byte(row.b, row.eoi);
		if (row.typed)
			awaited_results.push_back('{kind: row.kind, ch: row.ch, len: row.len,
				last: 1'b1});
		else
			foreach (step_results[i])
				awaited_results.push_back(step_results[i]);
	endtask

	task automatic send_text(input logic [7:0] b, input logic eoi);
		send_row('{b: b, eoi: eoi, typed: 1'b0, kind: lla_pkg::KIND_CHAR, ch: 8'h00,
			len: '0});
	endtask

	// only written once nothing is in flight
	task automatic write_max_len(input logic [12:0] v);
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_len_reg = v;
	endtask

	always @(posedge clk) begin : result_check
		line_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (m_axis_tuser == lla_pkg::KIND_LINE)
				lines_seen++;
			if (m_axis_tuser == lla_pkg::KIND_OVERFLOW)
				overflows_seen++;
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat kind %0d data %h last %0d",
					m_axis_tuser, m_axis_tdata, m_axis_tlast));
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tuser != want.kind || m_axis_tlast != want.last
						|| m_axis_tdata != {3'b000, want.len, want.ch})
					flag_mismatch($sformatf(
						"want kind %0d char %h len %0d last %0d, got kind %0d data %h last %0d",
						want.kind, want.ch, want.len, want.last,
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
			end
		end
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin : result_sink
		int r;
		int stretch;
		int held;
		forever begin
			if (squeeze_armed) begin
				squeeze_armed = 1'b0;
				m_axis_tready <= 1'b0;
				held = 0;
				while (held < 400) begin
					@(posedge clk);
					held++;
				end
			end
			r = $urandom_range(0, 99);
			if (r < 15) begin
				m_axis_tready <= 1'b0;
				stretch = (r < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end else begin
				m_axis_tready <= 1'b1;
				stretch = (r < 25) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			end
			repeat (stretch) begin
				@(posedge clk);
				if (squeeze_armed)
					break;
			end
		end
	end

	initial begin : stimulus
		text_row_t   directed_rows [N_DIRECTED];
		logic [12:0] phase_len [N_PHASES];
		logic [7:0]  b;
		logic        eoi;
		int          waited;
		directed_rows = '{
			// end of input on an empty line gives only the end mark
			'{lla_pkg::CH_NUL,  1'b1, 1'b1, lla_pkg::KIND_END,  8'h00, 13'd0},
			'{8'h61,            1'b0, 1'b1, lla_pkg::KIND_CHAR, 8'h61, 13'd0},
			'{lla_pkg::CH_SP,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_TAB,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{8'hff,            1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NL,   1'b0, 1'b1, lla_pkg::KIND_LINE, 8'h00, 13'd3},
			// leading blank, then a comment on an empty line
			'{lla_pkg::CH_SP,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_HASH, 1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{8'h78,            1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NL,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{8'h62,            1'b0, 1'b1, lla_pkg::KIND_CHAR, 8'h62, 13'd0},
			// literal backslash pair
			'{lla_pkg::CH_BSL,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{8'h71,            1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			// backslash then NUL drops the rest of the physical line
			'{lla_pkg::CH_BSL,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NUL,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NL,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			// plain continuation
			'{lla_pkg::CH_BSL,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NL,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			// bare NUL eats its line without ending the logical line
			'{lla_pkg::CH_NUL,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NL,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{8'h63,            1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_SP,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			// comment closes the line, held space left out of the length
			'{lla_pkg::CH_HASH, 1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_NL,   1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{lla_pkg::CH_BSL,  1'b0, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0},
			'{8'h00,            1'b1, 1'b0, lla_pkg::KIND_CHAR, 8'h00, 13'd0}
		};
		phase_len = '{13'd1, 13'd2, 13'd0, 13'd3, 13'd20, 13'd8191, 13'd7, 13'd4096,
			13'd0, 13'd0};
		phase_len[8] = 13'($urandom_range(1, 60));
		phase_len[9] = 13'($urandom_range(61, 300));

		parse_st = lla_pkg::MODE_NORMAL;
		held_space = 1'b0;
		line_count = '0;
		max_len_reg = 13'd256;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_row(directed_rows[i]);

		foreach (phase_len[p]) begin
			write_max_len(phase_len[p]);
			if (phase_len[p] == 13'd20)
				squeeze_armed = 1'b1;
			repeat (BYTES_PER_PHASE) begin
				pick_text(b, eoi);
				send_text(b, eoi);
			end
		end
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (awaited_results.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (awaited_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

		$display("tb: %0d bytes sent over %0d max_len settings, %0d results checked",
			bytes_accepted, N_PHASES + 1, results_checked);
		$display("tb: %0d lines completed, %0d overflows, %0d mismatches",
			lines_seen, overflows_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
